// ===== src/ufir_pkg.sv =====
// Shared types, register offsets, bit positions and reset values for the UART register block.
`default_nettype none

package ufir_pkg;

   // Width used for FIFO levels and trigger compares; it covers depths up to 127.
   localparam int LEVEL_W = 7;

   localparam int RX_DEPTH_DEFAULT = 16;
   localparam int TX_DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_LINE  = 2'd2,
      FUNC_TICK  = 2'd3
   } func_type;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ECHO   = 2'd1;
   localparam logic [1:0] MODE_LLOOP  = 2'd2;
   localparam logic [1:0] MODE_RLOOP  = 2'd3;

   localparam logic [4:0] REG_CONTROL      = 5'd0;
   localparam logic [4:0] REG_MODE         = 5'd1;
   localparam logic [4:0] REG_IRQ_ENABLE   = 5'd2;
   localparam logic [4:0] REG_IRQ_DISABLE  = 5'd3;
   localparam logic [4:0] REG_IRQ_MASK     = 5'd4;
   localparam logic [4:0] REG_IRQ_STATUS   = 5'd5;
   localparam logic [4:0] REG_BAUD_GEN     = 5'd6;
   localparam logic [4:0] REG_RX_TIMEOUT   = 5'd7;
   localparam logic [4:0] REG_RX_TRIGGER   = 5'd8;
   localparam logic [4:0] REG_MODEM_CTRL   = 5'd9;
   localparam logic [4:0] REG_MODEM_STAT   = 5'd10;
   localparam logic [4:0] REG_CHAN_STATUS  = 5'd11;
   localparam logic [4:0] REG_DATA         = 5'd12;
   localparam logic [4:0] REG_BAUD_DIV     = 5'd13;
   localparam logic [4:0] REG_FLOW_DELAY   = 5'd14;
   localparam logic [4:0] REG_PULSE_MIN    = 5'd15;
   localparam logic [4:0] REG_PULSE_WIDTH  = 5'd16;
   localparam logic [4:0] REG_TX_TRIGGER   = 5'd17;

   // Control register bits.
   localparam int CR_SRR = 0;
   localparam int CR_SRT = 1;
   localparam int CR_RE  = 2;
   localparam int CR_RD  = 3;
   localparam int CR_TE  = 4;
   localparam int CR_TD  = 5;

   // Interrupt status bits.
   localparam int IS_RTR = 0;
   localparam int IS_RE  = 1;
   localparam int IS_RF  = 2;
   localparam int IS_TE  = 3;
   localparam int IS_TF  = 4;
   localparam int IS_RO  = 5;
   localparam int IS_RT  = 8;
   localparam int IS_TI  = 10;
   localparam int IS_TO  = 12;

   // Channel status bits.
   localparam int CS_RTS = 0;
   localparam int CS_RES = 1;
   localparam int CS_RFS = 2;
   localparam int CS_TES = 3;
   localparam int CS_TFS = 4;
   localparam int CS_FTS = 13;

   localparam logic [8:0]  CTRL_RESET     = 9'h128;
   localparam logic [12:0] IS_RESET       = 13'h00A;
   localparam logic [13:0] CS_RESET       = 14'h000A;
   localparam logic [15:0] BAUD_GEN_RESET = 16'd4747;
   localparam logic [7:0]  BAUD_DIV_RESET = 8'd15;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } fifo_cmd_type;

   // Channel status as derived from the two FIFO levels.
   function automatic logic [13:0] chan_bits(input logic [LEVEL_W-1:0] rx_lvl,
                                             input logic [LEVEL_W-1:0] tx_lvl,
                                             input logic [LEVEL_W-1:0] trig,
                                             input logic [LEVEL_W-1:0] rx_depth,
                                             input logic [LEVEL_W-1:0] tx_depth);
      logic [13:0] s;
      s = '0;
      s[CS_RES] = (rx_lvl == '0);
      s[CS_RTS] = (rx_lvl >= trig);
      s[CS_RFS] = (rx_lvl == rx_depth);
      s[CS_TES] = (tx_lvl == '0);
      s[CS_FTS] = (tx_lvl >= tx_depth);
      s[CS_TFS] = (tx_lvl == tx_depth);
      return s;
   endfunction

   // Interrupt status bits that a channel status word sets.
   function automatic logic [12:0] status_from_chan(input logic [13:0] s);
      logic [12:0] b;
      b = '0;
      b[IS_RTR] = s[CS_RTS];
      b[IS_RE]  = s[CS_RES];
      b[IS_RF]  = s[CS_RFS];
      b[IS_TE]  = s[CS_TES];
      b[IS_TF]  = s[CS_TFS];
      b[IS_TI]  = s[CS_FTS];
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== src/ufir_fifo.sv =====
// Byte FIFO with head pointer and fill count, read combinationally at the head.
`default_nettype none

module ufir_fifo
   import ufir_pkg::*;
#(
   parameter int DEPTH = RX_DEPTH_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire fifo_cmd_type              cmd,
   input  wire  [7:0]                     wr_byte,
   output logic [7:0]                     rd_byte,
   output logic [$clog2(DEPTH+1)-1:0]     level,
   output logic [$clog2(DEPTH+1)-1:0]     level_next
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [7:0]       store_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] tail_sum;
   logic [PTR_W-1:0] tail;
   logic             full;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = cmd.push && !full && !cmd.clear;
   assign do_pop   = cmd.pop && (count_ff != '0) && !cmd.clear;

   // Head plus count stays below twice the depth, so one subtract wraps it.
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         head_in  = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[tail] <= wr_byte;
      end
   end

   assign rd_byte    = store_ff[head_ff];
   assign level      = count_ff;
   assign level_next = count_in;

endmodule

`default_nettype wire

// ===== src/uart_fifo_interrupt_registers.sv =====
// Top level: UART register view with receive and transmit FIFOs and sticky interrupts.
//
// The req_ channel carries one item per handshake: req_tuser holds the item kind
// (bus write, bus read, line byte received, transmitter ready) and req_tdata the
// register offset, the write data and the received line byte. Every item yields
// exactly one item on the rsp_ channel: read data, the interrupt line, and the
// byte leaving the transmit FIFO with its valid flag in rsp_tuser.
// The item accepted at a clock edge updates all registers and FIFOs at that
// edge, and its result is presented from the output register right after it.
// Throughput is one item per cycle while results are taken; the FIFO update
// and the status refresh fit between the input handshake and the output register.
// When the receiver stalls, the held result blocks new items only while it is
// not taken; req_tready is high whenever the output register is empty or is
// being emptied in the same cycle.
// Synchronous reset empties both FIFOs, loads the register reset values
// (control 0x128, status 0x00A, channel status 0x00A, baud values 4747 and 15,
// receive trigger equal to the receive depth) and drops rsp_tvalid.
`default_nettype none

module uart_fifo_interrupt_registers
   import ufir_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEFAULT,
   parameter int TX_DEPTH = TX_DEPTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,  // reg_index[4:0], write_data[36:5], line_byte[44:37], zeros
   input  wire  [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,  // read_data[31:0], irq_out[32], tx_byte[40:33], zeros
   output logic [0:0]  rsp_tuser   // tx_valid[0]
);

   localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
   localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

   func_type    func;
   logic [4:0]  reg_index;
   logic [31:0] write_data;
   logic [7:0]  line_byte;
   logic        take;
   logic [1:0]  mode;

   logic [8:0]  ctrl_ff, ctrl_in;
   logic [9:0]  mode_ff, mode_in;
   logic [12:0] mask_ff, mask_in;
   logic [12:0] status_ff, status_in;
   logic [13:0] chan_ff, chan_in;
   logic [15:0] baud_gen_ff, baud_gen_in;
   logic [7:0]  baud_div_ff, baud_div_in;
   logic [7:0]  timeout_ff, timeout_in;
   logic [5:0]  trigger_ff, trigger_in;
   logic [31:0] modem_ctrl_ff, modem_ctrl_in;
   logic [31:0] modem_stat_ff, modem_stat_in;
   logic        irq_ff, irq_in;

   logic        rsp_valid_ff;
   logic [31:0] read_data_ff, read_data_in;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic        tx_valid_ff;

   fifo_cmd_type        rx_cmd, tx_cmd;
   logic [7:0]          rx_wr, tx_wr, rx_rd, tx_rd;
   logic [RX_CNT_W-1:0] rx_level_raw, rx_next_raw;
   logic [TX_CNT_W-1:0] tx_level_raw, tx_next_raw;
   logic [LEVEL_W-1:0]  rx_level, rx_next, tx_level, tx_next;
   logic [LEVEL_W-1:0]  rx_depth_l, tx_depth_l, trig_l;

   logic is_write, is_read, is_line, is_tick;
   logic rx_try, tx_try, rx_push, tx_push, rx_pop, tx_pop;
   logic rx_full, tx_full, refresh, irq_reg_write;

   assign func       = func_type'(req_tuser);
   assign reg_index  = req_tdata[4:0];
   assign write_data = req_tdata[36:5];
   assign line_byte  = req_tdata[44:37];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign mode       = mode_ff[9:8];

   assign is_write = (func == FUNC_WRITE);
   assign is_read  = (func == FUNC_READ);
   assign is_line  = (func == FUNC_LINE);
   assign is_tick  = (func == FUNC_TICK);

   assign rx_level   = LEVEL_W'(rx_level_raw);
   assign rx_next    = LEVEL_W'(rx_next_raw);
   assign tx_level   = LEVEL_W'(tx_level_raw);
   assign tx_next    = LEVEL_W'(tx_next_raw);
   assign rx_depth_l = LEVEL_W'(RX_DEPTH);
   assign tx_depth_l = LEVEL_W'(TX_DEPTH);
   assign trig_l     = LEVEL_W'(trigger_ff);
   assign rx_full    = (rx_level == rx_depth_l);
   assign tx_full    = (tx_level == tx_depth_l);

   // Routing of bytes by channel mode; a line byte in echo mode goes to both FIFOs.
   assign rx_try = (is_write && reg_index == REG_DATA && mode == MODE_LLOOP)
                || (is_line && (mode == MODE_NORMAL || mode == MODE_ECHO));
   assign tx_try = (is_write && reg_index == REG_DATA && mode == MODE_NORMAL)
                || (is_line && (mode == MODE_ECHO || mode == MODE_RLOOP));
   assign rx_push = rx_try && !ctrl_ff[CR_RD] && ctrl_ff[CR_RE];
   assign tx_push = tx_try && !ctrl_ff[CR_TD] && ctrl_ff[CR_TE];
   assign rx_pop  = is_read && reg_index == REG_DATA && rx_level != '0;
   assign tx_pop  = is_tick && tx_level != '0;
   assign rx_wr   = is_line ? line_byte : write_data[7:0];
   assign tx_wr   = is_line ? line_byte : write_data[7:0];

   assign irq_reg_write = is_write && (reg_index == REG_IRQ_ENABLE
                                    || reg_index == REG_IRQ_DISABLE
                                    || reg_index == REG_IRQ_STATUS);
   assign refresh = rx_push || tx_push || rx_pop || tx_pop || irq_reg_write;

   always_comb begin
      rx_cmd.clear = take && is_write && reg_index == REG_CONTROL && write_data[CR_SRR];
      rx_cmd.push  = take && rx_push;
      rx_cmd.pop   = take && rx_pop;
      tx_cmd.clear = take && is_write && reg_index == REG_CONTROL && write_data[CR_SRT];
      tx_cmd.push  = take && tx_push;
      tx_cmd.pop   = take && tx_pop;
   end

   ufir_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
      .clock      (clock),
      .reset      (reset),
      .cmd        (rx_cmd),
      .wr_byte    (rx_wr),
      .rd_byte    (rx_rd),
      .level      (rx_level_raw),
      .level_next (rx_next_raw)
   );

   ufir_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tx_cmd),
      .wr_byte    (tx_wr),
      .rd_byte    (tx_rd),
      .level      (tx_level_raw),
      .level_next (tx_next_raw)
   );

   // Register writes and the status refresh.
   always_comb begin
      ctrl_in       = ctrl_ff;
      mode_in       = mode_ff;
      mask_in       = mask_ff;
      status_in     = status_ff;
      chan_in       = chan_ff;
      baud_gen_in   = baud_gen_ff;
      baud_div_in   = baud_div_ff;
      timeout_in    = timeout_ff;
      trigger_in    = trigger_ff;
      modem_ctrl_in = modem_ctrl_ff;
      modem_stat_in = modem_stat_ff;
      irq_in        = irq_ff;

      if (is_write) begin
         case (reg_index)
            REG_CONTROL:     ctrl_in       = {write_data[8:2], 2'b00};
            REG_MODE:        mode_in       = write_data[9:0];
            REG_IRQ_ENABLE:  mask_in       = mask_ff | write_data[12:0];
            REG_IRQ_DISABLE: mask_in       = mask_ff & ~write_data[12:0];
            REG_IRQ_STATUS:  status_in     = status_ff & ~write_data[12:0];
            REG_BAUD_GEN:    baud_gen_in   = write_data[15:0];
            REG_RX_TIMEOUT:  timeout_in    = write_data[7:0];
            REG_RX_TRIGGER:  trigger_in    = write_data[5:0];
            REG_MODEM_CTRL:  modem_ctrl_in = write_data;
            REG_MODEM_STAT:  modem_stat_in = write_data;
            REG_BAUD_DIV:    baud_div_in   = write_data[7:0];
            default:         ;
         endcase
      end

      if (rx_push && rx_full) begin
         status_in[IS_RO] = 1'b1;
      end
      if (rx_push && timeout_ff != '0) begin
         status_in[IS_RT] = 1'b1;
      end
      if (tx_push && tx_full) begin
         status_in[IS_TO] = 1'b1;
      end
      // An echoed byte refreshes once after the receive push, while the
      // transmit FIFO still has its old level, and again after the transmit push.
      if (rx_push && tx_push) begin
         status_in = status_in | status_from_chan(chan_bits(rx_next, tx_level, trig_l,
                                                            rx_depth_l, tx_depth_l));
      end
      if (refresh) begin
         chan_in   = chan_bits(rx_next, tx_next, trig_l, rx_depth_l, tx_depth_l);
         status_in = status_in | status_from_chan(chan_in);
         irq_in    = |(status_in & mask_in);
      end
   end

   always_comb begin
      read_data_in = '0;
      if (is_read) begin
         case (reg_index)
            REG_CONTROL:     read_data_in = 32'(ctrl_ff);
            REG_MODE:        read_data_in = 32'(mode_ff);
            REG_IRQ_MASK:    read_data_in = 32'(mask_ff);
            REG_IRQ_STATUS:  read_data_in = 32'(status_ff);
            REG_BAUD_GEN:    read_data_in = 32'(baud_gen_ff);
            REG_RX_TIMEOUT:  read_data_in = 32'(timeout_ff);
            REG_RX_TRIGGER:  read_data_in = 32'(trigger_ff);
            REG_MODEM_CTRL:  read_data_in = modem_ctrl_ff;
            REG_MODEM_STAT:  read_data_in = modem_stat_ff;
            REG_CHAN_STATUS: read_data_in = 32'(chan_ff);
            REG_DATA:        read_data_in = rx_pop ? 32'(rx_rd) : '0;
            REG_BAUD_DIV:    read_data_in = 32'(baud_div_ff);
            REG_TX_TRIGGER:  read_data_in = 32'(TX_DEPTH);
            default:         read_data_in = '0;
         endcase
      end
      tx_byte_in = tx_pop ? tx_rd : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff       <= CTRL_RESET;
         mode_ff       <= '0;
         mask_ff       <= '0;
         status_ff     <= IS_RESET;
         chan_ff       <= CS_RESET;
         baud_gen_ff   <= BAUD_GEN_RESET;
         baud_div_ff   <= BAUD_DIV_RESET;
         timeout_ff    <= '0;
         trigger_ff    <= 6'(RX_DEPTH);
         modem_ctrl_ff <= '0;
         modem_stat_ff <= '0;
         irq_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            ctrl_ff       <= ctrl_in;
            mode_ff       <= mode_in;
            mask_ff       <= mask_in;
            status_ff     <= status_in;
            chan_ff       <= chan_in;
            baud_gen_ff   <= baud_gen_in;
            baud_div_ff   <= baud_div_in;
            timeout_ff    <= timeout_in;
            trigger_ff    <= trigger_in;
            modem_ctrl_ff <= modem_ctrl_in;
            modem_stat_ff <= modem_stat_in;
            irq_ff        <= irq_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         read_data_ff <= read_data_in;
         tx_byte_ff   <= tx_byte_in;
         tx_valid_ff  <= tx_pop;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, tx_byte_ff, irq_ff, read_data_ff};
   assign rsp_tuser  = tx_valid_ff;

endmodule

`default_nettype wire

// ===== src/ufir_checker.sv =====
// Port-level checks for the UART register block, bound to the top level.
`default_nettype none

module ufir_checker
   import ufir_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [1:0]  req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata,
   input wire [0:0]  rsp_tuser
);

   // A held result does not change until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Every accepted item produces its result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   // Only a bus read returns data, and only a transmitter tick sends a byte.
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != FUNC_READ && req_tuser != FUNC_TICK
      |=> rsp_tdata[31:0] == 32'd0 && rsp_tuser[0] == 1'b0)
      else $error("read data or tx byte set for the wrong item kind");

   a_tx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[40:33] == 8'd0)
      else $error("tx_byte nonzero without tx_valid");

endmodule

bind uart_fifo_interrupt_registers ufir_checker u_ufir_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
